// ===== design/kiss_pkg.sv =====
`timescale 1ns / 1ps

package kiss_pkg;

  // Field widths
  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;
  localparam int unsigned CfgIdxW = 2;

  // Command codes
  localparam logic CMD_RESEED = 1'b0;
  localparam logic CMD_DRAW   = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SEED_Z     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEED_W     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEED_JSR   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SEED_JCONG = 2'd3;

  // Seed values after reset
  localparam logic [WordW-1:0] RST_SEED_Z     = 32'd362436069;
  localparam logic [WordW-1:0] RST_SEED_W     = 32'd521288629;
  localparam logic [WordW-1:0] RST_SEED_JSR   = 32'd123456789;
  localparam logic [WordW-1:0] RST_SEED_JCONG = 32'd380116160;

  // Generator constants
  localparam logic [WordW-1:0] MWC_Z_MULT = 32'd36969;
  localparam logic [WordW-1:0] MWC_W_MULT = 32'd18000;
  localparam logic [WordW-1:0] CONG_MULT  = 32'd69069;
  localparam logic [WordW-1:0] CONG_INC   = 32'd12345;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_Z,
    ST_MUL_W,
    ST_MUL_CONG,
    ST_CONG_ADD,
    ST_COMBINE,
    ST_MUL_RANGE,
    ST_RANGE_OUT
  } state_e;

endpackage

// ===== design/kiss_random_generator.sv =====
`timescale 1ns / 1ps

// KISS random generator with one shared 32x32 multiplier. A reseed transfer
// (command 0) loads the four state words from the seed registers in the
// accepting cycle and returns nothing; the block is ready again the next cycle.
// A draw transfer (command 1) runs a seven-step sequence on the shared
// multiplier: the two multiply-with-carry products, the congruential product,
// the combine, and the range product word * (range_high - range_low), to which
// the word itself is added to form word * span. When the output register is
// free, the result is registered in the last step and the block returns to
// idle, where it takes the next item; no new item is accepted while a draw
// runs its sequence. The output register holds a result until it is taken,
// and a new draw waits in its last step only if the previous result is still
// pending.
// random_word read as unsigned 0.32 is the uniform fraction, read as signed
// Q1.31 the symmetric value. Seed writes may come at any time and take effect
// at the next reseed transfer.
module kiss_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] random_word_o,
  output logic [31:0] range_value_o
);

  import kiss_pkg::*;

  // Seed registers
  logic [WordW-1:0] seed_z_q, seed_w_q, seed_jsr_q, seed_jcong_q;

  // Generator state
  logic [WordW-1:0] z_q, z_d, w_q, w_d, jsr_q, jsr_d, jcong_q, jcong_d;

  // Working registers
  state_e             state_q, state_d;
  logic [WordW-1:0]   low_q, low_d;
  logic [WordW-1:0]   diff_q, diff_d;
  logic [WordW-1:0]   word_q, word_d;
  logic [2*WordW-1:0] prod_q;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_word_q, out_word_d;
  logic [WordW-1:0] out_range_q, out_range_d;

  // Shared multiplier
  logic [WordW-1:0]   mul_a, mul_b;
  logic [2*WordW-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Xorshift step
  logic [WordW-1:0] xs1, xs2, xs3;
  assign xs1 = jsr_q ^ (jsr_q << 17);
  assign xs2 = xs1 ^ (xs1 >> 13);
  assign xs3 = xs2 ^ (xs2 << 5);

  // Final range sum: word * diff + word, upper half, plus low
  logic [2*WordW:0] scaled_sum;
  assign scaled_sum = {1'b0, prod_q} + {{(WordW+1){1'b0}}, word_q};

  logic in_xfer;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer and datapath control
  always_comb begin
    state_d     = state_q;
    z_d         = z_q;
    w_d         = w_q;
    jsr_d       = jsr_q;
    jcong_d     = jcong_q;
    low_d       = low_q;
    diff_d      = diff_q;
    word_d      = word_q;
    out_word_d  = out_word_q;
    out_range_d = out_range_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_a       = MWC_Z_MULT;
    mul_b       = {{HalfW{1'b0}}, z_q[HalfW-1:0]};
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (command_i == CMD_RESEED) begin
            z_d     = seed_z_q;
            w_d     = seed_w_q;
            jsr_d   = seed_jsr_q;
            jcong_d = seed_jcong_q;
          end else begin
            low_d   = range_low_i;
            diff_d  = range_high_i - range_low_i;
            state_d = ST_MUL_Z;
          end
        end
      end
      ST_MUL_Z: begin
        mul_a   = MWC_Z_MULT;
        mul_b   = {{HalfW{1'b0}}, z_q[HalfW-1:0]};
        state_d = ST_MUL_W;
      end
      ST_MUL_W: begin
        z_d     = prod_q[WordW-1:0] + (z_q >> HalfW);
        mul_a   = MWC_W_MULT;
        mul_b   = {{HalfW{1'b0}}, w_q[HalfW-1:0]};
        state_d = ST_MUL_CONG;
      end
      ST_MUL_CONG: begin
        w_d     = prod_q[WordW-1:0] + (w_q >> HalfW);
        jsr_d   = xs3;
        mul_a   = CONG_MULT;
        mul_b   = jcong_q;
        state_d = ST_CONG_ADD;
      end
      ST_CONG_ADD: begin
        jcong_d = prod_q[WordW-1:0] + CONG_INC;
        state_d = ST_COMBINE;
      end
      ST_COMBINE: begin
        word_d  = (((z_q << HalfW) + w_q) ^ jcong_q) + jsr_q;
        state_d = ST_MUL_RANGE;
      end
      ST_MUL_RANGE: begin
        mul_a   = word_q;
        mul_b   = diff_q;
        state_d = ST_RANGE_OUT;
      end
      ST_RANGE_OUT: begin
        // keep the range product steady while waiting
        mul_a = word_q;
        mul_b = diff_q;
        // wait here only while the previous result is not yet taken
        if (!out_valid_q || out_ready_i) begin
          out_word_d  = word_q;
          out_range_d = scaled_sum[2*WordW-1:WordW] + low_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      z_q         <= RST_SEED_Z;
      w_q         <= RST_SEED_W;
      jsr_q       <= RST_SEED_JSR;
      jcong_q     <= RST_SEED_JCONG;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      z_q         <= z_d;
      w_q         <= w_d;
      jsr_q       <= jsr_d;
      jcong_q     <= jcong_d;
    end
  end

  // Seed registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_z_q     <= RST_SEED_Z;
      seed_w_q     <= RST_SEED_W;
      seed_jsr_q   <= RST_SEED_JSR;
      seed_jcong_q <= RST_SEED_JCONG;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SEED_Z:     seed_z_q     <= cfg_wdata_i;
        CFG_SEED_W:     seed_w_q     <= cfg_wdata_i;
        CFG_SEED_JSR:   seed_jsr_q   <= cfg_wdata_i;
        CFG_SEED_JCONG: seed_jcong_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    low_q       <= low_d;
    diff_q      <= diff_d;
    word_q      <= word_d;
    prod_q      <= mul_p;
    out_word_q  <= out_word_d;
    out_range_q <= out_range_d;
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;
  assign range_value_o = out_range_q;

endmodule

// ===== test/tb_kiss_random_generator.sv =====
`timescale 1ns / 1ps

module tb_kiss_random_generator;
  import kiss_pkg::*;

  localparam int unsigned TimeoutCycles = 400000;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned PhaseItems    = 230;

  // DUT inputs, all known from time zero
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [1:0]  cfg_index_i  = '0;
  logic [31:0] cfg_wdata_i  = '0;
  logic        in_valid_i   = 1'b0;
  logic        command_i    = CMD_DRAW;
  logic [31:0] range_low_i  = '0;
  logic [31:0] range_high_i = '0;
  logic        out_ready_i  = 1'b0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] random_word_o;
  logic [31:0] range_value_o;

  // sender/receiver control shared with the main sequence
  bit          hold_off_req = 1'b0;
  bit          no_idle      = 1'b0;
  int unsigned cycle_count  = 0;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] value;
  } draw_result_t;

  // Generator model plus queue of draws still owed by the block
  class kiss_scoreboard;
    logic [31:0]  seed_z, seed_w, seed_jsr, seed_jcong;
    logic [31:0]  mwc_z, mwc_w, xs_word, lcg_word;
    draw_result_t owed_draws[$];
    int           mismatches;

    function new();
      seed_z     = RST_SEED_Z;
      seed_w     = RST_SEED_W;
      seed_jsr   = RST_SEED_JSR;
      seed_jcong = RST_SEED_JCONG;
      mwc_z      = seed_z;
      mwc_w      = seed_w;
      xs_word    = seed_jsr;
      lcg_word   = seed_jcong;
      mismatches = 0;
    endfunction

    function void set_seed(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_SEED_Z:     seed_z = val;
        CFG_SEED_W:     seed_w = val;
        CFG_SEED_JSR:   seed_jsr = val;
        CFG_SEED_JCONG: seed_jcong = val;
        default: ;
      endcase
    endfunction

    // Accepted input: reseed loads state, draw advances it and owes a result
    function void note_input(logic cmd, logic [31:0] lo, logic [31:0] hi);
      logic [32:0]  span;
      logic [63:0]  product;
      draw_result_t res;
      if (cmd == CMD_RESEED) begin
        mwc_z    = seed_z;
        mwc_w    = seed_w;
        xs_word  = seed_jsr;
        lcg_word = seed_jcong;
      end else begin
        mwc_z    = MWC_Z_MULT * {16'b0, mwc_z[15:0]} + {16'b0, mwc_z[31:16]};
        mwc_w    = MWC_W_MULT * {16'b0, mwc_w[15:0]} + {16'b0, mwc_w[31:16]};
        lcg_word = CONG_MULT * lcg_word + CONG_INC;
        xs_word  = xs_word ^ (xs_word << 17);
        xs_word  = xs_word ^ (xs_word >> 13);
        xs_word  = xs_word ^ (xs_word << 5);
        res.word = (({mwc_z[15:0], 16'b0} + mwc_w) ^ lcg_word) + xs_word;
        // span is 33 bits so the full range gives 2^32; reversed ranges wrap
        span      = {1'b0, hi - lo} + 33'd1;
        product   = {32'b0, res.word} * {31'b0, span};
        res.value = product[63:32] + lo;
        owed_draws.push_back(res);
      end
    endfunction

    function void check_output(logic [31:0] word, logic [31:0] value);
      draw_result_t exp_res;
      if (owed_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: random_word %h range_value %h", word, value);
        return;
      end
      exp_res = owed_draws.pop_front();
      if (word !== exp_res.word || value !== exp_res.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: random_word exp %h got %h, range_value exp %h got %h",
                   exp_res.word, word, exp_res.value, value);
      end
    endfunction

    function int outstanding();
      return owed_draws.size();
    endfunction
  endclass

  kiss_scoreboard sb;

  kiss_random_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .range_low_i   (range_low_i),
    .range_high_i  (range_high_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .random_word_o (random_word_o),
    .range_value_o (range_value_o)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TimeoutCycles) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Transfer monitors, sampled at the edge before the DUT updates
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_input(command_i, range_low_i, range_high_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_output(random_word_o, range_value_o);
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: random ready runs and stalls, plus one long hold-off on request
  initial begin : receiver
    int run;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 99) < 60) begin
        run = $urandom_range(1, 20);
        out_ready_i <= 1'b1;
        repeat (run) @(posedge clk_i);
      end else begin
        run = pick_gap() + 1;
        out_ready_i <= 1'b0;
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // Offer one item; valid stays up from the previous transfer when there is no gap
  task automatic send_item(input logic cmd, input logic [31:0] lo, input logic [31:0] hi);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    range_low_i  <= lo;
    range_high_i <= hi;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Wait until every owed draw has come back and the block has gone quiet
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seeds(input logic [31:0] z, input logic [31:0] w,
                             input logic [31:0] jsr, input logic [31:0] cong);
    logic [31:0] vals[4];
    logic [1:0]  idx[4];
    vals = '{z, w, jsr, cong};
    idx  = '{CFG_SEED_Z, CFG_SEED_W, CFG_SEED_JSR, CFG_SEED_JCONG};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= vals[i];
      sb.set_seed(idx[i], vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Range shapes: full, narrow, arbitrary (often reversed), small, single, top end
  task automatic pick_range(output logic [31:0] lo, output logic [31:0] hi);
    case ($urandom_range(0, 5))
      0: begin lo = '0; hi = '1; end
      1: begin lo = $urandom; hi = lo + $urandom_range(0, 15); end
      2: begin lo = $urandom; hi = $urandom; end
      3: begin lo = $urandom_range(0, 100); hi = $urandom_range(100, 1000); end
      4: begin lo = $urandom; hi = lo; end
      default: begin lo = $urandom; hi = 32'hFFFF_FFFF - $urandom_range(0, 3); end
    endcase
  endtask

  // Main sequence
  initial begin
    logic [31:0] lo, hi;
    logic        cmd;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: range extremes with the reset seeds
    send_item(CMD_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CMD_DRAW, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_DRAW, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(CMD_DRAW, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_DRAW, 32'h0000_0001, 32'h0000_0000);
    send_item(CMD_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CMD_DRAW, 32'h0000_000A, 32'h0000_0013);
    wait_idle();

    // zero xorshift seed
    write_seeds(RST_SEED_Z, RST_SEED_W, 32'h0000_0000, RST_SEED_JCONG);
    send_item(CMD_RESEED, 32'h0000_0000, 32'h0000_0000);
    repeat (3) send_item(CMD_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);
    wait_idle();

    // all-zero seeds
    write_seeds('0, '0, '0, '0);
    send_item(CMD_RESEED, 32'h5555_5555, 32'hAAAA_AAAA);
    repeat (3) send_item(CMD_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);
    wait_idle();

    // all-ones seeds
    write_seeds('1, '1, '1, '1);
    send_item(CMD_RESEED, 32'hAAAA_AAAA, 32'h5555_5555);
    repeat (3) send_item(CMD_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);

    // random phases, each with fresh seeds
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      write_seeds($urandom, $urandom, $urandom, $urandom);
      no_idle = (p == 1);
      send_item(CMD_RESEED, $urandom, $urandom);
      for (int n = 0; n < PhaseItems; n++) begin
        // long receiver stall while the sender keeps offering
        if (p == 2 && n == 40)
          hold_off_req = 1'b1;
        pick_range(lo, hi);
        cmd = ($urandom_range(0, 99) < 12) ? CMD_RESEED : CMD_DRAW;
        send_item(cmd, lo, hi);
      end
    end
    no_idle = 1'b0;
    wait_idle();

    if (sb.outstanding() != 0)
      $display("%0d draws never returned", sb.outstanding());
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/kiss_pkg.sv
design/kiss_random_generator.sv
test/tb_kiss_random_generator.sv
